### hdl/psg_pkg.sv
// Package for the plane span generator: field widths, register codes and the
// structs passed between the front end, the item queue and the span engine.
// No dependencies.
package psg_pkg;

	// Field widths fixed by the stream and register formats.
	localparam int CLIP_W      = 7;
	localparam int COL_W       = 9;
	localparam int SPAN_ROW_W  = 6;
	localparam int VW_W        = 10;
	localparam int VH_W        = 7;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 24;
	localparam int CFG_ADDR_W  = 4;
	localparam int CFG_DATA_W  = 32;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_VIEW_WIDTH  = 2'd0;
	localparam logic [1:0] REG_VIEW_HEIGHT = 2'd1;
	localparam logic [1:0] REG_SKY_ON      = 2'd2;

	// One classified column as it waits in the queue.
	typedef struct packed {
		logic                     flush;
		logic [COL_W-1:0]         col;
		logic signed [CLIP_W-1:0] floor_clip;
		logic [CLIP_W-1:0]        ceil_clip;
	} psg_item_t;

	// Effective configuration seen by the span engine.
	typedef struct packed {
		logic [VH_W-1:0]  height;
		logic [COL_W-1:0] width_m1;
		logic             sky;
		logic             restart;
	} psg_cfg_t;

endpackage

### hdl/psg_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module psg_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data holds while re is low.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hdl/psg_front.sv
// Front end of the plane span generator: configuration registers, input
// acceptance, clip saturation and column numbering. Depends on psg_pkg.
module psg_front #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 512
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [psg_pkg::CFG_ADDR_W-1:0]       paddr,
	input  logic [psg_pkg::CFG_DATA_W-1:0]       pwdata,
	output logic [psg_pkg::CFG_DATA_W-1:0]       prdata,
	output logic                                 pready,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [psg_pkg::IN_TDATA_W-1:0]       s_tdata,
	output logic                                 push,
	output psg_pkg::psg_item_t                   push_item,
	input  logic                                 q_full,
	output psg_pkg::psg_cfg_t                    cfg
);
	import psg_pkg::*;

	logic [VW_W-1:0]          view_width_q;
	logic [VH_W-1:0]          view_height_q;
	logic                     sky_on_q;
	logic                     restart_q;
	logic [COL_W-1:0]         col_q;
	logic                     pend_q;
	logic [1:0]               reg_idx;
	logic                     wr_en;
	logic [VH_W-1:0]          eff_h;
	logic [VW_W-1:0]          eff_w;
	logic signed [CLIP_W-1:0] h_m1;
	logic [CLIP_W-1:0]        c_raw;
	logic [CLIP_W-1:0]        c_sat;
	logic signed [CLIP_W-1:0] f_raw;
	logic signed [CLIP_W-1:0] f_lo;
	logic signed [CLIP_W-1:0] f_sat;
	logic signed [CLIP_W:0]   c_m1;
	logic signed [CLIP_W:0]   f_ext;
	logic signed [CLIP_W-1:0] f_fin;
	logic [COL_W-1:0]         x_eff;
	logic                     col_last;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// Register file; a write to a defined register restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_width_q  <= VW_W'(320);
			view_height_q <= VH_W'(64);
			sky_on_q      <= 1'b0;
			restart_q     <= 1'b0;
		end else begin
			restart_q <= 1'b0;
			if (wr_en) begin
				unique case (reg_idx)
					REG_VIEW_WIDTH: begin
						view_width_q <= pwdata[VW_W-1:0];
						restart_q    <= 1'b1;
					end
					REG_VIEW_HEIGHT: begin
						view_height_q <= pwdata[VH_W-1:0];
						restart_q     <= 1'b1;
					end
					REG_SKY_ON: begin
						sky_on_q  <= pwdata[0];
						restart_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Register readback.
	always_comb begin
		unique case (reg_idx)
			REG_VIEW_WIDTH:  prdata = {{(CFG_DATA_W-VW_W){1'b0}}, view_width_q};
			REG_VIEW_HEIGHT: prdata = {{(CFG_DATA_W-VH_W){1'b0}}, view_height_q};
			REG_SKY_ON:      prdata = {{(CFG_DATA_W-1){1'b0}}, sky_on_q};
			default:         prdata = '0;
		endcase
	end

	// Effective view size, with zero acting as one and large values capped.
	always_comb begin
		if (view_height_q == '0) begin
			eff_h = VH_W'(1);
		end else if (view_height_q > VH_W'(MAX_ROWS)) begin
			eff_h = VH_W'(MAX_ROWS);
		end else begin
			eff_h = view_height_q;
		end
		if (view_width_q == '0) begin
			eff_w = VW_W'(1);
		end else if (view_width_q > VW_W'(MAX_COLS)) begin
			eff_w = VW_W'(MAX_COLS);
		end else begin
			eff_w = view_width_q;
		end
	end

	assign h_m1 = $signed(eff_h - VH_W'(1));

	// Clip saturation, then, with sky off, the floor clip is raised above crossed ceilings.
	always_comb begin
		c_raw = s_tdata[CLIP_W-1:0];
		f_raw = $signed(s_tdata[2*CLIP_W-1:CLIP_W]);
		c_sat = (c_raw > eff_h) ? eff_h : c_raw;
		f_lo  = (f_raw < -7'sd1) ? -7'sd1 : f_raw;
		f_sat = (f_lo > h_m1) ? h_m1 : f_lo;
		c_m1  = $signed({1'b0, c_sat}) - 8'sd1;
		f_ext = {f_sat[CLIP_W-1], f_sat};
		if (!sky_on_q && (f_ext < c_m1)) begin
			f_fin = c_m1[CLIP_W-1:0];
		end else begin
			f_fin = f_sat;
		end
	end

	// Column numbering; a flush is owed once the last column has gone by.
	assign x_eff    = pend_q ? '0 : col_q;
	assign col_last = ({1'b0, x_eff} + VW_W'(1)) >= eff_w;

	assign s_tready = !q_full;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		push_item.flush      = pend_q;
		push_item.col        = x_eff;
		push_item.floor_clip = f_fin;
		push_item.ceil_clip  = c_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			pend_q <= 1'b0;
		end else if (wr_en && (reg_idx == REG_VIEW_WIDTH || reg_idx == REG_VIEW_HEIGHT ||
				reg_idx == REG_SKY_ON)) begin
			col_q  <= '0;
			pend_q <= 1'b0;
		end else if (push) begin
			if (col_last) begin
				col_q  <= x_eff;
				pend_q <= 1'b1;
			end else begin
				col_q  <= x_eff + COL_W'(1);
				pend_q <= 1'b0;
			end
		end
	end

	always_comb begin
		cfg.height   = eff_h;
		cfg.width_m1 = COL_W'(eff_w - VW_W'(1));
		cfg.sky      = sky_on_q;
		cfg.restart  = restart_q;
	end

endmodule

### hdl/psg_queue.sv
// Two-entry queue of classified columns between the front end and the span
// engine. Depends on psg_pkg.
module psg_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  psg_pkg::psg_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               pop_valid,
	output psg_pkg::psg_item_t pop_item
);
	import psg_pkg::*;

	psg_item_t  ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_item  = ent_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

### hdl/psg_back.sv
// Span engine of the plane span generator: row pointers, start-column stores,
// the open/close sequencer and the output register. Depends on psg_pkg and
// psg_ram.
module psg_back #(
	parameter int MAX_ROWS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  psg_pkg::psg_cfg_t                  cfg,
	input  logic                               q_valid,
	input  psg_pkg::psg_item_t                 q_item,
	output logic                               q_pop,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [psg_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic                               m_tlast,
	output logic                               m_tuser
);
	import psg_pkg::*;

	localparam int RA_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_FLC  = 5'b00010,
		ST_FLF  = 5'b00100,
		ST_CEIL = 5'b01000,
		ST_FLR  = 5'b10000
	} state_t;

	state_t                   state_q, state_d;
	logic [CLIP_W-1:0]        ceil_q, ceil_d;
	logic signed [CLIP_W-1:0] floor_q, floor_d;
	psg_item_t                item_q, item_d;
	logic                     more_ff_q, more_ff_d;
	logic                     more_cc_q, more_cc_d;
	logic                     more_fl_q, more_fl_d;

	logic signed [CLIP_W-1:0] h_m1;
	logic signed [CLIP_W-1:0] floor_nx;
	logic [CLIP_W-1:0]        ceil_nx;
	logic [CLIP_W-1:0]        ceil_base;
	logic signed [CLIP_W-1:0] floor_base;

	logic                     emit;
	logic [CLIP_W-1:0]        emit_row;
	logic [COL_W-1:0]         emit_right;
	logic                     emit_flr;
	logic                     emit_last;
	logic                     we_c;
	logic                     we_f;
	logic [CLIP_W-1:0]        wrow;
	logic                     ren_c;
	logic                     ren_f;
	logic [COL_W-1:0]         rdata_c;
	logic [COL_W-1:0]         rdata_f;

	logic                     vld_s1;
	logic [SPAN_ROW_W-1:0]    row_s1;
	logic [COL_W-1:0]         right_s1;
	logic                     flr_s1;
	logic                     last_s1;
	logic                     s1_adv;
	logic                     rd_ok;

	logic                     out_vld_q;
	logic [SPAN_ROW_W-1:0]    out_row_q;
	logic [COL_W-1:0]         out_left_q;
	logic [COL_W-1:0]         out_right_q;
	logic                     out_flr_q;
	logic                     out_last_q;

	assign h_m1       = $signed(cfg.height - VH_W'(1));
	assign floor_nx   = floor_q + 7'sd1;
	assign ceil_nx    = ceil_q - CLIP_W'(1);
	assign ceil_base  = q_item.flush ? '0 : ceil_q;
	assign floor_base = q_item.flush ? h_m1 : floor_q;

	// A read may start when the read stage is empty or moving on.
	assign s1_adv = vld_s1 && (!out_vld_q || m_tready);
	assign rd_ok  = !vld_s1 || s1_adv;

	// Sequencer: at most one store write or one span read per cycle; a span read waits while the read stage is held.
	always_comb begin
		state_d    = state_q;
		ceil_d     = ceil_q;
		floor_d    = floor_q;
		item_d     = item_q;
		more_ff_d  = more_ff_q;
		more_cc_d  = more_cc_q;
		more_fl_d  = more_fl_q;
		q_pop      = 1'b0;
		emit       = 1'b0;
		emit_row   = '0;
		emit_flr   = 1'b0;
		emit_right = item_q.col - COL_W'(1);
		emit_last  = 1'b0;
		we_c       = 1'b0;
		we_f       = 1'b0;
		wrow       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop     = 1'b1;
					item_d    = q_item;
					more_ff_d = q_item.flush && (floor_q < h_m1);
					more_cc_d = !cfg.sky && (ceil_base > q_item.ceil_clip);
					more_fl_d = floor_base < $signed(q_item.floor_clip);
					state_d   = q_item.flush ? ST_FLC : ST_CEIL;
				end
			end
			ST_FLC: begin
				if (ceil_q == '0) begin
					state_d = ST_FLF;
				end else if (rd_ok) begin
					emit       = 1'b1;
					emit_row   = ceil_nx;
					emit_right = cfg.width_m1;
					emit_last  = (ceil_q == CLIP_W'(1)) &&
						!(more_ff_q || more_cc_q || more_fl_q);
					ceil_d     = ceil_nx;
				end
			end
			ST_FLF: begin
				if (floor_q == h_m1) begin
					state_d = ST_CEIL;
				end else if (rd_ok) begin
					emit       = 1'b1;
					emit_row   = $unsigned(floor_nx);
					emit_flr   = 1'b1;
					emit_right = cfg.width_m1;
					emit_last  = (floor_nx == h_m1) && !(more_cc_q || more_fl_q);
					floor_d    = floor_nx;
				end
			end
			ST_CEIL: begin
				if (cfg.sky || (ceil_q == item_q.ceil_clip)) begin
					state_d = ST_FLR;
				end else if (ceil_q < item_q.ceil_clip) begin
					we_c   = 1'b1;
					wrow   = ceil_q;
					ceil_d = ceil_q + CLIP_W'(1);
				end else if (rd_ok) begin
					emit      = 1'b1;
					emit_row  = ceil_nx;
					emit_last = (ceil_nx == item_q.ceil_clip) && !more_fl_q;
					ceil_d    = ceil_nx;
				end
			end
			ST_FLR: begin
				if (floor_q == $signed(item_q.floor_clip)) begin
					state_d = ST_IDLE;
				end else if (floor_q > $signed(item_q.floor_clip)) begin
					we_f    = 1'b1;
					wrow    = $unsigned(floor_q);
					floor_d = floor_q - 7'sd1;
				end else if (rd_ok) begin
					emit      = 1'b1;
					emit_row  = $unsigned(floor_nx);
					emit_flr  = 1'b1;
					emit_last = floor_nx == $signed(item_q.floor_clip);
					floor_d   = floor_nx;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		// A write to a defined register discards all open rows.
		if (cfg.restart) begin
			ceil_d  = '0;
			floor_d = h_m1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ceil_q    <= '0;
			floor_q   <= CLIP_W'(MAX_ROWS - 1);
			more_ff_q <= 1'b0;
			more_cc_q <= 1'b0;
			more_fl_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			ceil_q    <= ceil_d;
			floor_q   <= floor_d;
			more_ff_q <= more_ff_d;
			more_cc_q <= more_cc_d;
			more_fl_q <= more_fl_d;
		end
	end

	always_ff @(posedge clk) begin
		item_q <= item_d;
	end

	// Start-column stores for ceiling and floor rows.
	assign ren_c = emit && !emit_flr;
	assign ren_f = emit && emit_flr;

	psg_ram #(
		.WIDTH (COL_W),
		.DEPTH (MAX_ROWS)
	) u_ceil_ram (
		.clk   (clk),
		.we    (we_c),
		.waddr (wrow[RA_W-1:0]),
		.wdata (item_q.col),
		.re    (ren_c),
		.raddr (emit_row[RA_W-1:0]),
		.rdata (rdata_c)
	);

	psg_ram #(
		.WIDTH (COL_W),
		.DEPTH (MAX_ROWS)
	) u_floor_ram (
		.clk   (clk),
		.we    (we_f),
		.waddr (wrow[RA_W-1:0]),
		.wdata (item_q.col),
		.re    (ren_f),
		.raddr (emit_row[RA_W-1:0]),
		.rdata (rdata_f)
	);

	// Read stage: span fields wait here for the store data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (emit) begin
			vld_s1 <= 1'b1;
		end else if (s1_adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			row_s1   <= emit_row[SPAN_ROW_W-1:0];
			right_s1 <= emit_right;
			flr_s1   <= emit_flr;
			last_s1  <= emit_last;
		end
	end

	// Output register holding one beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_adv) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_row_q   <= row_s1;
			out_left_q  <= flr_s1 ? rdata_f : rdata_c;
			out_right_q <= right_s1;
			out_flr_q   <= flr_s1;
			out_last_q  <= last_s1;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {out_right_q, out_left_q, out_row_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_flr_q;

	// The sequencer touches at most one store port per cycle.
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ren_c, ren_f, we_c, we_f}))
		else $error("more than one store access in a cycle");

	// Between columns, with sky off, the floor pointer never sits more than one row above the ceiling pointer.
	a_no_cross: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) && !cfg.sky |->
		($signed({floor_q[CLIP_W-1], floor_q}) >= ($signed({1'b0, ceil_q}) - 8'sd1)))
		else $error("floor and ceiling pointers crossed");

	// A waiting read stays put while the output is stalled.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && out_vld_q && !m_tready |=> vld_s1 && $stable(row_s1) && $stable(flr_s1))
		else $error("read stage lost a span under back-pressure");

endmodule

### hdl/plane_span_generator_core.sv
// Top level of the plane span generator: register port, column input stream
// and span output stream. Depends on psg_pkg, psg_front, psg_queue, psg_back.
//
// Use: write view_width (0x0), view_height (0x4) and sky_on (0x8) over the
// register port while the block is idle; each write restarts the frame at
// column 0 and drops any open rows. Then send one beat per screen column on
// the s_ channel: tdata[6:0] ceiling_clip, tdata[13:7] floor_clip. The block
// answers with spans on the m_ channel, one beat each; tlast marks the last
// span caused by a column, and a column that opens or keeps rows gives none.
// After the last column of a frame, the open rows are flushed ahead of the
// next column's own spans.
// Flow: a column is loaded, then the sequencer visits each phase it needs
// (ceiling and floor, and two flush phases at a frame start) and opens or
// closes its rows, making one start-store write or one span read per cycle.
// Spans leave at up to one per cycle, through the read stage and then the
// output register. A two-entry queue lets columns arrive while earlier ones
// are worked off, and the read stage and output register hold spans while
// m_tready is low, stalling the sequencer only when both are full. Reset
// restores the register defaults (320 columns, 64 rows, sky off) and an
// empty frame; the start stores need no clearing.
module plane_span_generator_core #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 512
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [psg_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [psg_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [psg_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                             pready,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// tdata from bit 0: ceiling_clip[6:0], floor_clip[13:7], zero fill [15:14]
	input  logic [psg_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// tdata from bit 0: span_row[5:0], span_left[14:6], span_right[23:15]
	output logic [psg_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                             m_tlast,
	// tuser: is_floor[0]
	output logic                             m_tuser
);
	import psg_pkg::*;

	logic      push;
	psg_item_t push_item;
	logic      q_full;
	logic      q_pop;
	logic      q_valid;
	psg_item_t q_item;
	psg_cfg_t  cfg;

	// Registers, saturation and column numbering.
	psg_front #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full),
		.cfg       (cfg)
	);

	// Column queue.
	psg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_item  (q_item)
	);

	// Span engine.
	psg_back #(
		.MAX_ROWS (MAX_ROWS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

### verif/tb_plane_span_generator_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for plane_span_generator_core: column beats go in,
// floor and ceiling span beats are predicted in step and checked field by field.
// Depends on psg_pkg and plane_span_generator_core.
module tb_plane_span_generator_core;
	import psg_pkg::*;

	localparam int ROWS_MAX      = 64;
	localparam int COLS_MAX      = 512;
	// Covers a column that opens every row after its spans have left, plus
	// the columns still waiting in the queue.
	localparam int SETTLE_CYCLES = 200;
	localparam int STALL_LIMIT   = 2000;
	// Register slot past the last defined one; writes there are dropped.
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [5:0] row;
		logic [8:0] left;
		logic [8:0] right;
		logic       is_floor;
		logic       is_last;
	} span_t;

	logic                   clk;
	logic                   arst_n;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [CFG_ADDR_W-1:0]  paddr;
	logic [CFG_DATA_W-1:0]  pwdata;
	logic [CFG_DATA_W-1:0]  prdata;
	logic                   pready;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic                   m_tuser;

	// Spans still owed by the block, oldest first.
	span_t pending_spans[$];
	int    span_errors;
	bit    idle_on;
	int    stall_left;
	int    quiet_cycles;

	// Shadow of the block: registers, open rows and start columns.
	logic [9:0]  view_width;
	logic [6:0]  view_height;
	logic        sky_on;
	logic [8:0]  ceil_start [ROWS_MAX];
	logic [8:0]  floor_start [ROWS_MAX];
	int          ceil_open;
	int          floor_open;
	int unsigned col_idx;
	bit          flush_due;

	plane_span_generator_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int eff_rows();
		if (view_height == 7'd0) return 1;
		if (view_height > ROWS_MAX) return ROWS_MAX;
		return int'(view_height);
	endfunction

	function automatic void restart_frame();
		ceil_open  = 0;
		floor_open = eff_rows() - 1;
		col_idx    = 0;
		flush_due  = 1'b0;
	endfunction

	function automatic void add_span(input int row, input logic [8:0] left,
			input logic [8:0] right, input logic is_floor);
		span_t s;
		s.row      = 6'(row);
		s.left     = left;
		s.right    = right;
		s.is_floor = is_floor;
		s.is_last  = 1'b0;
		pending_spans.push_back(s);
	endfunction

	// Works out the spans caused by one accepted column and queues them.
	function automatic void plan_column_spans(input logic [6:0] c_raw,
			input logic [6:0] f_raw);
		int          h;
		int unsigned w;
		int          c;
		int          f;
		int          y;
		int          n;
		logic [8:0]  x;
		logic [8:0]  right;
		h = eff_rows();
		w = (view_width == 10'd0) ? 1 : ((view_width > COLS_MAX) ? COLS_MAX : view_width);
		n = 0;

		// Rows left open by the previous frame close at its right edge.
		if (flush_due) begin
			y = ceil_open;
			while (y > 0) begin
				y--;
				add_span(y, ceil_start[y], 9'(w - 1), 1'b0);
				n++;
			end
			y = floor_open;
			while (y < h - 1) begin
				y++;
				add_span(y, floor_start[y], 9'(w - 1), 1'b1);
				n++;
			end
			restart_frame();
		end

		x     = 9'(col_idx);
		right = x - 9'd1;

		// Saturate both clips to the view.
		c = int'(c_raw);
		if (c > h) c = h;
		f = $signed(f_raw);
		if (f < -1) f = -1;
		if (f > h - 1) f = h - 1;

		// Ceiling pass; the floor is pushed below the ceiling when they cross.
		if (!sky_on) begin
			if (f < c - 1) f = c - 1;
			y = ceil_open;
			while (y < c) begin
				ceil_start[y] = x;
				y++;
			end
			while (y > c) begin
				y--;
				add_span(y, ceil_start[y], right, 1'b0);
				n++;
			end
			ceil_open = y;
		end

		// Floor pass.
		y = floor_open;
		while (y > f) begin
			floor_start[y] = x;
			y--;
		end
		while (y < f) begin
			y++;
			add_span(y, floor_start[y], right, 1'b1);
			n++;
		end
		floor_open = y;

		if (x + 1 >= w) flush_due = 1'b1;
		else col_idx = x + 1;

		if (n > 0) pending_spans[pending_spans.size() - 1].is_last = 1'b1;
	endfunction

	// Columns are predicted as they are accepted; span beats are checked as they leave.
	always @(posedge clk) begin
		span_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) plan_column_spans(s_tdata[6:0], s_tdata[13:7]);
			if (m_tvalid && m_tready) begin
				if (pending_spans.size() == 0) begin
					$error("unexpected span beat: row %0d left %0d right %0d",
						m_tdata[5:0], m_tdata[14:6], m_tdata[23:15]);
					span_errors++;
				end else begin
					want = pending_spans.pop_front();
					if (m_tdata[5:0] !== want.row) begin
						$error("span_row: expected %0d, got %0d", want.row, m_tdata[5:0]);
						span_errors++;
					end
					if (m_tdata[14:6] !== want.left) begin
						$error("span_left: expected %0d, got %0d", want.left, m_tdata[14:6]);
						span_errors++;
					end
					if (m_tdata[23:15] !== want.right) begin
						$error("span_right: expected %0d, got %0d", want.right, m_tdata[23:15]);
						span_errors++;
					end
					if (m_tuser !== want.is_floor) begin
						$error("is_floor: expected %0d, got %0d", want.is_floor, m_tuser);
						span_errors++;
					end
					if (m_tlast !== want.is_last) begin
						$error("last_span: expected %0d, got %0d", want.is_last, m_tlast);
						span_errors++;
					end
				end
			end
		end
	end

	// Output back-pressure in short random bursts.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			stall_left = $urandom_range(0, 3);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Ends the run when no beat and no register access moves for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable) || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_plane_span_generator_core: FAIL");
			$finish;
		end
	end

	// Sends one column beat, sometimes after a short gap.
	task automatic send_column(input logic [6:0] c_raw, input logic [6:0] f_raw);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, f_raw, c_raw};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Waits until every owed span has left and the block has gone quiet.
	task automatic drain_spans();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_spans.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		drain_spans();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_VIEW_WIDTH: begin
				view_width = value[9:0];
				restart_frame();
			end
			REG_VIEW_HEIGHT: begin
				view_height = value[6:0];
				restart_frame();
			end
			REG_SKY_ON: begin
				sky_on = value[0];
				restart_frame();
			end
			default: ;
		endcase
	endtask

	task automatic read_reg(input logic [1:0] idx, input logic [31:0] want, input string name);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== want) begin
			$error("%s: expected %0d, got %0d", name, want, prdata);
			span_errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic test_register_defaults();
		read_reg(REG_VIEW_WIDTH, 32'd320, "view_width");
		read_reg(REG_VIEW_HEIGHT, 32'd64, "view_height");
		read_reg(REG_SKY_ON, 32'd0, "sky_on");
		send_column(7'd10, 7'd50);
		send_column(7'd5, 7'd55);
	endtask

	// Clips far outside the view, including the most negative floor clip.
	task automatic test_clip_saturation();
		write_reg(REG_VIEW_WIDTH, 32'd6);
		write_reg(REG_VIEW_HEIGHT, 32'd8);
		write_reg(REG_SKY_ON, 32'd0);
		send_column(7'd127, 7'h40);
		send_column(7'd0, 7'd63);
		send_column(7'd64, 7'h7F);
		send_column(7'd3, 7'd5);
		send_column(7'd2, 7'd6);
		send_column(7'd8, 7'h7F);
		send_column(7'd1, 7'd7);
	endtask

	// Floor clip above the ceiling clip, with unused write data bits set.
	task automatic test_crossed_clips();
		write_reg(REG_VIEW_WIDTH, 32'hFFFF_FC04);
		read_reg(REG_VIEW_WIDTH, 32'd4, "view_width");
		write_reg(REG_VIEW_HEIGHT, 32'hFFFF_FF90);
		read_reg(REG_VIEW_HEIGHT, 32'd16, "view_height");
		send_column(7'd10, 7'd2);
		send_column(7'd4, 7'd3);
		send_column(7'd12, 7'd14);
		send_column(7'd0, 7'h7F);
		send_column(7'd6, 7'd9);
	endtask

	task automatic test_sky_mode();
		write_reg(REG_VIEW_WIDTH, 32'd3);
		write_reg(REG_VIEW_HEIGHT, 32'd8);
		write_reg(REG_SKY_ON, 32'hFFFF_FFFF);
		read_reg(REG_SKY_ON, 32'd1, "sky_on");
		send_column(7'd5, 7'd2);
		send_column(7'd0, 7'd7);
		send_column(7'd8, 7'h7F);
		send_column(7'd3, 7'd3);
	endtask

	// A write past the last register must leave the frame running.
	task automatic test_ignored_register();
		write_reg(REG_VIEW_WIDTH, 32'd5);
		write_reg(REG_VIEW_HEIGHT, 32'd12);
		write_reg(REG_SKY_ON, 32'd0);
		send_column(7'd4, 7'd6);
		send_column(7'd7, 7'd9);
		write_reg(REG_UNUSED, 32'd1);
		read_reg(REG_VIEW_WIDTH, 32'd5, "view_width");
		send_column(7'd2, 7'd10);
		send_column(7'd6, 7'd4);
		send_column(7'd1, 7'd11);
		send_column(7'd3, 7'd8);
	endtask

	// One setting of the registers, then columns whose clips mostly wander
	// like wall edges, with jumps and raw noise mixed in.
	task automatic run_frames(input logic [9:0] width, input logic [6:0] height,
			input logic sky, input int columns, input bit idling);
		int         h;
		int         c;
		int         f;
		logic [6:0] c_raw;
		logic [6:0] f_raw;
		write_reg(REG_VIEW_WIDTH, {22'd0, width});
		write_reg(REG_VIEW_HEIGHT, {25'd0, height});
		write_reg(REG_SKY_ON, {31'd0, sky});
		idle_on = idling;
		h = eff_rows();
		c = $urandom_range(0, h);
		f = int'($urandom_range(0, h)) - 1;
		for (int i = 0; i < columns; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				c_raw = 7'($urandom);
				f_raw = 7'($urandom);
			end else begin
				if ($urandom_range(0, 7) == 0) begin
					c = $urandom_range(0, h);
					f = int'($urandom_range(0, h)) - 1;
				end else begin
					c += int'($urandom_range(0, 4)) - 2;
					f += int'($urandom_range(0, 4)) - 2;
				end
				if (c < 0) c = 0;
				if (c > h) c = h;
				if (f < -1) f = -1;
				if (f > h - 1) f = h - 1;
				c_raw = 7'(c);
				f_raw = 7'(f);
			end
			send_column(c_raw, f_raw);
		end
	endtask

	task automatic test_random_frames();
		run_frames(10'd260, 7'd40, 1'b0, 265, 1'b1);
		run_frames(10'd0, 7'd0, 1'b0, 12, 1'b1);
		run_frames(10'd1, 7'd8, 1'b1, 20, 1'b1);
		run_frames(10'd1023, 7'd127, 1'b0, 40, 1'b0);
		run_frames(10'($urandom_range(2, 40)), 7'($urandom_range(1, 64)), 1'($urandom), 50, 1'b1);
		run_frames(10'($urandom_range(2, 40)), 7'($urandom_range(1, 64)), 1'($urandom), 50, 1'b1);
		run_frames(10'd17, 7'd64, 1'b0, 60, 1'b0);
	endtask

	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		m_tready    = 1'b1;
		span_errors = 0;
		stall_left  = 0;
		quiet_cycles = 0;
		idle_on     = 1'b1;
		view_width  = 10'd320;
		view_height = 7'd64;
		sky_on      = 1'b0;
		restart_frame();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_defaults();
		test_clip_saturation();
		test_crossed_clips();
		test_sky_mode();
		test_ignored_register();
		test_random_frames();
		drain_spans();

		if (span_errors == 0) begin
			$display("tb_plane_span_generator_core: PASS");
		end else begin
			$display("tb_plane_span_generator_core: FAIL");
		end
		$finish;
	end

endmodule

### sim.f
hdl/psg_pkg.sv
hdl/psg_ram.sv
hdl/psg_front.sv
hdl/psg_queue.sv
hdl/psg_back.sv
hdl/plane_span_generator_core.sv
verif/tb_plane_span_generator_core.sv
